// ===== rtl/core/ecg_frame_decode_calibrate_assert.svh =====
// ----------------------------------------------------------------------------
// ECG frame decode assertion macros
// Clocked, reset-qualified assertion helpers for the frame decoder.
// ----------------------------------------------------------------------------
`ifndef ECG_FRAME_DECODE_CALIBRATE_ASSERT_SVH
`define ECG_FRAME_DECODE_CALIBRATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ECG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ECG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ECG_ASSERT(lbl, prop, msg)
`define ECG_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/efdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ECG frame decode package
// Shared widths, constants, register codes and queue types.
// ----------------------------------------------------------------------------
`default_nettype none

package efdc_pkg;

  localparam int RAW_W      = 24;
  localparam int UV_W       = 23;
  localparam int STATUS_W   = 8;
  localparam int CNT_W      = 32;
  localparam int WIN_W      = 16;
  localparam int SPAN_W     = 8;
  localparam int TOP_W      = 9;
  localparam int GAIN_W     = 40;
  localparam int OFFS_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int K_W        = 31;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [STATUS_W-1:0] GOOD_STATUS = 8'hC0;
  // 2.42e6 / 8388607 in Q0.32
  localparam logic [K_W-1:0]      UV_SCALE    = 31'd1239040148;

  localparam logic [WIN_W-1:0]  RST_WIN_FIRST = 16'd1;
  localparam logic [WIN_W-1:0]  RST_WIN_LAST  = 16'd1000;
  localparam logic [SPAN_W-1:0] RST_SPAN0     = 8'd180;
  localparam logic [TOP_W-1:0]  RST_TOP0      = 9'd220;
  localparam logic [SPAN_W-1:0] RST_SPAN1     = 8'd2;
  localparam logic [TOP_W-1:0]  RST_TOP1      = 9'd1;

  localparam logic signed [UV_W-1:0] UV_MOST_POS = {1'b0, {(UV_W-1){1'b1}}};
  localparam logic signed [UV_W-1:0] UV_MOST_NEG = {1'b1, {(UV_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_FIRST = 3'd0,
    CFG_WIN_LAST  = 3'd1,
    CFG_SPAN0     = 3'd2,
    CFG_TOP0      = 3'd3,
    CFG_SPAN1     = 3'd4,
    CFG_TOP1      = 3'd5
  } efdc_cfg_idx_e;

  typedef struct packed {
    logic                   good;
    logic signed [UV_W-1:0] uv0;
    logic signed [UV_W-1:0] uv1;
  } efdc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } efdc_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/efdc_front.sv =====
// ----------------------------------------------------------------------------
// ECG frame decode front end
// Takes frames, checks the status byte and scales both channels to microvolts.
// ----------------------------------------------------------------------------
`default_nettype none

module efdc_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [efdc_pkg::STATUS_W-1:0]  status_byte_i,
  input  wire  [efdc_pkg::RAW_W-1:0]     raw_ch0_i,
  input  wire  [efdc_pkg::RAW_W-1:0]     raw_ch1_i,
  input  wire  efdc_pkg::efdc_qstat_t    q_stat_i,
  output logic                           q_push_o,
  output efdc_pkg::efdc_item_t           q_item_o
);
  import efdc_pkg::*;

  localparam int PROD_W = RAW_W + K_W;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_e;

  fstate_e                 state_q;
  logic                    good_q;
  logic [RAW_W-1:0]        raw_q [2];
  logic                    neg_q [2];
  logic [UV_W-1:0]         p_q   [2];
  logic [RAW_W-1:0]        mag   [2];
  logic [PROD_W-1:0]       prod  [2];
  logic signed [UV_W-1:0]  uv    [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i]  = raw_q[i][RAW_W-1] ? (RAW_W'(0) - raw_q[i]) : raw_q[i];
      prod[i] = {{K_W{1'b0}}, mag[i]} * {{RAW_W{1'b0}}, UV_SCALE};
      uv[i]   = neg_q[i] ? (UV_W'(0) - p_q[i]) : p_q[i];
    end
  end

  assign in_stall_o    = (state_q != F_IDLE);
  assign q_push_o      = (state_q == F_PUSH) && !q_stat_i.full;
  assign q_item_o.good = good_q;
  assign q_item_o.uv0  = uv[0];
  assign q_item_o.uv1  = uv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            good_q   <= (status_byte_i == GOOD_STATUS);
            raw_q[0] <= raw_ch0_i;
            raw_q[1] <= raw_ch1_i;
            state_q  <= F_MUL;
          end
        end
        F_MUL: begin
          for (int i = 0; i < 2; i++) begin
            p_q[i]   <= prod[i][PROD_W-1:32];
            neg_q[i] <= raw_q[i][RAW_W-1];
          end
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_stat_i.full) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/efdc_fifo.sv =====
// ----------------------------------------------------------------------------
// ECG frame decode queue
// Short register queue between the front end and the calibration back end.
// ----------------------------------------------------------------------------
`default_nettype none

module efdc_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire efdc_pkg::efdc_item_t item_i,
  input  wire                   pop_i,
  output efdc_pkg::efdc_item_t  item_o,
  output efdc_pkg::efdc_qstat_t stat_o
);
  import efdc_pkg::*;

  efdc_item_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/efdc_back.sv =====
// ----------------------------------------------------------------------------
// ECG frame decode back end
// Counts good frames, tracks min/max in the window and computes gain/offset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ecg_frame_decode_calibrate_assert.svh"

module efdc_back (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [efdc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [efdc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire  efdc_pkg::efdc_item_t           q_item_i,
  input  wire  efdc_pkg::efdc_qstat_t          q_stat_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 frame_ok_o,
  output logic signed [efdc_pkg::UV_W-1:0]     uv_ch0_o,
  output logic signed [efdc_pkg::UV_W-1:0]     uv_ch1_o,
  output logic                                 calib_ready_o,
  output logic                                 calib_error_o,
  output logic [efdc_pkg::GAIN_W-1:0]          gain_ch0_o,
  output logic signed [efdc_pkg::OFFS_W-1:0]   offset_ch0_o,
  output logic [efdc_pkg::GAIN_W-1:0]          gain_ch1_o,
  output logic signed [efdc_pkg::OFFS_W-1:0]   offset_ch1_o
);
  import efdc_pkg::*;

  localparam int DIV_STEPS = GAIN_W;
  localparam int BIT_W     = $clog2(DIV_STEPS);
  localparam int MUL_A_W   = 32;
  localparam int MUL_W     = MUL_A_W + UV_W;
  localparam int PHI_W     = GAIN_W - MUL_A_W + UV_W;
  localparam int PQ_W      = GAIN_W + UV_W;
  localparam int X_W       = 64;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_DIV, S_MLO, S_MHI, S_SUM, S_OFS
  } state_e;

  // configuration
  logic [WIN_W-1:0]         win_first_q;
  logic [WIN_W-1:0]         win_last_q;
  logic [SPAN_W-1:0]        span_q [2];
  logic signed [TOP_W-1:0]  top_q  [2];

  // control and running state
  state_e                   state_q;
  logic                     out_valid_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     done_q;
  logic signed [UV_W-1:0]   min_q [2];
  logic signed [UV_W-1:0]   max_q [2];
  logic                     ch_q;
  logic [BIT_W-1:0]         bit_q;

  // calibration datapath
  logic [UV_W-1:0]          div_q;
  logic [UV_W-1:0]          rem_q;
  logic [GAIN_W-1:0]        qd_q;
  logic [UV_W-1:0]          mmag_q;
  logic                     mneg_q;
  logic [MUL_W-1:0]         plo_q;
  logic [PHI_W-1:0]         phi_q;
  logic [PQ_W-1:0]          pq_q;

  // result register
  logic                     ok_q;
  logic signed [UV_W-1:0]   uv_q   [2];
  logic                     rdy_q;
  logic                     err_q  [2];
  logic [GAIN_W-1:0]        gain_q [2];
  logic signed [OFFS_W-1:0] offs_q [2];

  logic signed [UV_W-1:0]   cur_mn;
  logic signed [UV_W-1:0]   cur_mx;
  logic                     cur_err;
  logic [UV_W:0]            diff;
  logic [UV_W:0]            div_t;
  logic                     div_ge;
  logic [UV_W-1:0]          div_rem;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_W-1:0]         mul_p;
  logic [X_W-1:0]           tq;
  logic [X_W-1:0]           ofs_x;
  logic [CNT_W-1:0]         cnt_nx;
  logic                     in_win;
  logic                     past;
  logic                     go_cal;
  logic                     out_fire;
  logic                     pop;

  always_comb begin
    cur_mn  = min_q[ch_q];
    cur_mx  = max_q[ch_q];
    cur_err = !(cur_mx > cur_mn);
    diff    = {cur_mx[UV_W-1], cur_mx} - {cur_mn[UV_W-1], cur_mn};
    div_t   = {rem_q, qd_q[GAIN_W-1]};
    div_ge  = (div_t >= {1'b0, div_q});
    div_rem = div_ge ? UV_W'(div_t - {1'b0, div_q}) : div_t[UV_W-1:0];
    mul_a   = (state_q == S_MLO) ? qd_q[MUL_A_W-1:0]
                                 : {{(2*MUL_A_W-GAIN_W){1'b0}}, qd_q[GAIN_W-1:MUL_A_W]};
    mul_p   = {{UV_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mmag_q};
    tq      = {{(X_W-TOP_W-32){top_q[ch_q][TOP_W-1]}}, top_q[ch_q], 32'b0};
    ofs_x   = mneg_q ? (tq + {{(X_W-PQ_W){1'b0}}, pq_q})
                     : (tq - {{(X_W-PQ_W){1'b0}}, pq_q});
    cnt_nx  = cnt_q + 1'b1;
    in_win  = (cnt_nx >= {{(CNT_W-WIN_W){1'b0}}, win_first_q}) &&
              (cnt_nx <= {{(CNT_W-WIN_W){1'b0}}, win_last_q});
    past    = (cnt_nx >  {{(CNT_W-WIN_W){1'b0}}, win_last_q});
    go_cal  = q_item_i.good && !done_q && !in_win && past;
  end

  assign out_fire      = out_valid_q && !out_stall_i;
  assign pop           = (state_q == S_IDLE) && !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign q_pop_o       = pop;
  assign cfg_ready_o   = 1'b1;

  assign out_valid_o   = out_valid_q;
  assign frame_ok_o    = ok_q;
  assign uv_ch0_o      = uv_q[0];
  assign uv_ch1_o      = uv_q[1];
  assign calib_ready_o = rdy_q;
  assign calib_error_o = err_q[0] | err_q[1];
  assign gain_ch0_o    = gain_q[0];
  assign gain_ch1_o    = gain_q[1];
  assign offset_ch0_o  = offs_q[0];
  assign offset_ch1_o  = offs_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_first_q <= RST_WIN_FIRST;
      win_last_q  <= RST_WIN_LAST;
      span_q[0]   <= RST_SPAN0;
      top_q[0]    <= RST_TOP0;
      span_q[1]   <= RST_SPAN1;
      top_q[1]    <= RST_TOP1;
    end else if (cfg_valid_i) begin
      case (efdc_cfg_idx_e'(cfg_index_i))
        CFG_WIN_FIRST: win_first_q <= cfg_data_i[WIN_W-1:0];
        CFG_WIN_LAST:  win_last_q  <= cfg_data_i[WIN_W-1:0];
        CFG_SPAN0:     span_q[0]   <= cfg_data_i[SPAN_W-1:0];
        CFG_TOP0:      top_q[0]    <= cfg_data_i[TOP_W-1:0];
        CFG_SPAN1:     span_q[1]   <= cfg_data_i[SPAN_W-1:0];
        CFG_TOP1:      top_q[1]    <= cfg_data_i[TOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      min_q[0]    <= UV_MOST_POS;
      min_q[1]    <= UV_MOST_POS;
      max_q[0]    <= UV_MOST_NEG;
      max_q[1]    <= UV_MOST_NEG;
      ch_q        <= 1'b0;
      bit_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            ok_q      <= q_item_i.good;
            uv_q[0]   <= q_item_i.good ? q_item_i.uv0 : '0;
            uv_q[1]   <= q_item_i.good ? q_item_i.uv1 : '0;
            rdy_q     <= 1'b0;
            err_q[0]  <= 1'b0;
            err_q[1]  <= 1'b0;
            gain_q[0] <= '0;
            gain_q[1] <= '0;
            offs_q[0] <= '0;
            offs_q[1] <= '0;
            if (q_item_i.good) begin
              cnt_q <= cnt_nx;
              if (!done_q && in_win) begin
                if (q_item_i.uv0 < min_q[0]) min_q[0] <= q_item_i.uv0;
                if (q_item_i.uv0 > max_q[0]) max_q[0] <= q_item_i.uv0;
                if (q_item_i.uv1 < min_q[1]) min_q[1] <= q_item_i.uv1;
                if (q_item_i.uv1 > max_q[1]) max_q[1] <= q_item_i.uv1;
              end
            end
            if (go_cal) begin
              done_q      <= 1'b1;
              ch_q        <= 1'b0;
              out_valid_q <= 1'b0;
              state_q     <= S_SETUP;
            end else begin
              out_valid_q <= 1'b1;
            end
          end else if (out_fire) begin
            out_valid_q <= 1'b0;
          end
        end
        S_SETUP: begin
          if (cur_err) begin
            err_q[ch_q]  <= 1'b1;
            gain_q[ch_q] <= '0;
            offs_q[ch_q] <= '0;
            if (!ch_q) begin
              ch_q <= 1'b1;
            end else begin
              rdy_q       <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else begin
            div_q   <= diff[UV_W-1:0];
            rem_q   <= '0;
            qd_q    <= {span_q[ch_q], {(GAIN_W-SPAN_W){1'b0}}};
            bit_q   <= '0;
            mmag_q  <= cur_mx[UV_W-1] ? (UV_W'(0) - cur_mx) : cur_mx;
            mneg_q  <= cur_mx[UV_W-1];
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= div_rem;
          qd_q  <= {qd_q[GAIN_W-2:0], div_ge};
          bit_q <= bit_q + 1'b1;
          if (bit_q == BIT_W'(DIV_STEPS-1)) begin
            state_q <= S_MLO;
          end
        end
        S_MLO: begin
          plo_q   <= mul_p;
          state_q <= S_MHI;
        end
        S_MHI: begin
          phi_q   <= mul_p[PHI_W-1:0];
          state_q <= S_SUM;
        end
        S_SUM: begin
          pq_q    <= {{(PQ_W-MUL_W){1'b0}}, plo_q} + {phi_q, {MUL_A_W{1'b0}}};
          state_q <= S_OFS;
        end
        S_OFS: begin
          gain_q[ch_q] <= qd_q;
          offs_q[ch_q] <= ofs_x[X_W-1:X_W-OFFS_W];
          if (!ch_q) begin
            ch_q    <= 1'b1;
            state_q <= S_SETUP;
          end else begin
            rdy_q       <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ECG_ASSERT(a_busy_no_result, (state_q != S_IDLE) |-> !out_valid_q, "result shown during calibration")
  `ECG_ASSERT_NEVER(a_done_sticky, $fell(done_q), "calibration done flag cleared")
  `ECG_ASSERT(a_div_rem_bound, (state_q == S_DIV) |-> (rem_q < div_q), "divider remainder out of range")
  `ECG_ASSERT(a_ready_after_done, (out_valid_q && rdy_q) |-> done_q, "calibration result without done")

endmodule

`default_nettype wire

// ===== rtl/core/ecg_frame_decode_calibrate.sv =====
// ----------------------------------------------------------------------------
// ECG frame decode and calibrate
// Two-channel converter frame decoder with one-shot min/max normalization.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one frame per beat (status byte
// and two 24-bit words). Output channel: out_valid_o / out_stall_i carry one
// result per frame. Config: cfg_valid_i / cfg_ready_o write register
// cfg_index_i with cfg_data_i; ready is always high, write only when idle.
// A plain frame goes through capture, scale multiply, queue push and the
// output register before out_valid_o rises. The front end takes a new frame
// only after the last one is pushed (capture, scale multiply, queue push).
// The frame that closes the window also runs the gain/offset pass: per
// channel a setup step, a restoring divider, then multiply and offset add.
// Reset clears the good-frame count, the calibration flag and the min/max
// trackers and loads the register defaults; no clearing pass is needed.
// A stalled result holds in the output register while the front end keeps
// taking frames into a 2-beat queue; once that fills, in_stall_o stays high.
// ----------------------------------------------------------------------------
`default_nettype none

module ecg_frame_decode_calibrate (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [efdc_pkg::STATUS_W-1:0]        status_byte_i,
  input  wire  [efdc_pkg::RAW_W-1:0]           raw_ch0_i,
  input  wire  [efdc_pkg::RAW_W-1:0]           raw_ch1_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 frame_ok_o,
  output logic signed [efdc_pkg::UV_W-1:0]     uv_ch0_o,
  output logic signed [efdc_pkg::UV_W-1:0]     uv_ch1_o,
  output logic                                 calib_ready_o,
  output logic                                 calib_error_o,
  output logic [efdc_pkg::GAIN_W-1:0]          gain_ch0_o,
  output logic signed [efdc_pkg::OFFS_W-1:0]   offset_ch0_o,
  output logic [efdc_pkg::GAIN_W-1:0]          gain_ch1_o,
  output logic signed [efdc_pkg::OFFS_W-1:0]   offset_ch1_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [efdc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [efdc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import efdc_pkg::*;

  efdc_qstat_t q_stat;
  efdc_item_t  push_item;
  efdc_item_t  head_item;
  logic        q_push;
  logic        q_pop;

  efdc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .status_byte_i (status_byte_i),
    .raw_ch0_i     (raw_ch0_i),
    .raw_ch1_i     (raw_ch1_i),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  efdc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  efdc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .q_item_i      (head_item),
    .q_stat_i      (q_stat),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_ok_o    (frame_ok_o),
    .uv_ch0_o      (uv_ch0_o),
    .uv_ch1_o      (uv_ch1_o),
    .calib_ready_o (calib_ready_o),
    .calib_error_o (calib_error_o),
    .gain_ch0_o    (gain_ch0_o),
    .offset_ch0_o  (offset_ch0_o),
    .gain_ch1_o    (gain_ch1_o),
    .offset_ch1_o  (offset_ch1_o)
  );

endmodule

`default_nettype wire
